FILE: hdl/cvm_pkg.sv
// Shared types and constants for the convergence monitor.
// Word formats, stage tag, verdict codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package cvm_pkg;

  // Field widths
  localparam int WEIGHT_W = 24;
  localparam int DIFF_W   = 25;
  localparam int SQ_W     = 49;
  localparam int ACC_W    = 58;
  localparam int ITER_W   = 32;
  localparam int PAT_W    = 16;
  localparam int REG_IDX_W = 2;

  // 1.0 in Q.32, the step charged for every element of the first vector
  localparam logic [SQ_W-1:0] ONE_Q32 = {{(SQ_W-33){1'b0}}, 1'b1, 32'd0};

  // Verdict codes
  localparam logic [1:0] VERDICT_CONTINUE  = 2'd0;
  localparam logic [1:0] VERDICT_CONVERGED = 2'd1;
  localparam logic [1:0] VERDICT_LIMIT     = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_SQ   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITERATIONS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATIENCE       = 2'd2;

  // Input word
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } cvm_in_t;

  // Result word
  typedef struct packed {
    logic [1:0]       verdict;
    logic [ACC_W-1:0] distance_sq;
  } cvm_out_t;

  // Control carried alongside each element through the pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic over_limit;
    logic first;
  } cvm_tag_t;

endpackage

FILE: hdl/cvm_front.sv
// Front stage: element index, vector control state and previous-vector store.
// Depends on cvm_pkg.
`timescale 1ns / 1ps

module cvm_front
  import cvm_pkg::*;
#(
  parameter int NUM_WEIGHTS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  cvm_in_t             in_data,
  input  logic [ITER_W-1:0]   max_iterations,
  output cvm_tag_t            tag1,
  output logic [WEIGHT_W-1:0] weight1,
  output logic [WEIGHT_W-1:0] prev1
);

  localparam int IDX_W = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_WEIGHTS - 1);

  logic [IDX_W-1:0]    element_index;
  logic [ITER_W-1:0]   iteration_counter;
  logic                first_pass;
  logic                over_limit;
  logic                accept;
  logic                ovl_now;
  logic [IDX_W-1:0]    element_index_next;
  logic [WEIGHT_W-1:0] store [NUM_WEIGHTS];

  assign accept = in_valid & en;

  // Limit check is made afresh at every index zero
  assign ovl_now = (element_index == '0) ? (iteration_counter > max_iterations) : over_limit;

  always_comb begin
    if (in_data.last || element_index == IDX_LAST) begin
      element_index_next = '0;
    end else begin
      element_index_next = element_index + IDX_W'(1);
    end
  end

  // Vector control state
  always_ff @(posedge clk) begin
    if (rst) begin
      element_index     <= '0;
      iteration_counter <= ITER_W'(1);
      first_pass        <= 1'b1;
      over_limit        <= 1'b0;
    end else if (accept) begin
      element_index <= element_index_next;
      over_limit    <= ovl_now;
      if (in_data.last && !ovl_now) begin
        first_pass <= 1'b0;
        if (iteration_counter != '1) begin
          iteration_counter <= iteration_counter + ITER_W'(1);
        end
      end
    end
  end

  // Stage tag
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else if (en) begin
      tag1.valid      <= accept;
      tag1.last       <= in_data.last;
      tag1.over_limit <= ovl_now;
      tag1.first      <= first_pass;
    end
  end

  // Store: read returns the old entry, write replaces it on the same edge unless over the limit
  always_ff @(posedge clk) begin
    if (accept) begin
      prev1   <= store[element_index];
      weight1 <= in_data.weight;
      if (!ovl_now) begin
        store[element_index] <= in_data.weight;
      end
    end
  end

endmodule

FILE: hdl/cvm_square.sv
// Difference and square stage: squared step of one element in Q.32.
// Depends on cvm_pkg.
`timescale 1ns / 1ps

module cvm_square
  import cvm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  cvm_tag_t            tag1,
  input  logic [WEIGHT_W-1:0] weight1,
  input  logic [WEIGHT_W-1:0] prev1,
  output cvm_tag_t            tag2,
  output logic [SQ_W-1:0]     sq2
);

  logic [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]   mag;
  logic [2*DIFF_W-1:0] prod;

  // Signed difference, magnitude, exact square (at most 2^48)
  assign diff = {weight1[WEIGHT_W-1], weight1} - {prev1[WEIGHT_W-1], prev1};
  assign mag  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
  assign prod = {{DIFF_W{1'b0}}, mag} * {{DIFF_W{1'b0}}, mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
    end else if (en) begin
      tag2 <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq2 <= tag1.first ? ONE_Q32 : prod[SQ_W-1:0];
    end
  end

endmodule

FILE: hdl/cvm_accum.sv
// Accumulate stage: saturating sum, patience count, verdict and result register.
// Depends on cvm_pkg.
`timescale 1ns / 1ps

module cvm_accum
  import cvm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  cvm_tag_t         tag2,
  input  logic [SQ_W-1:0]  sq2,
  input  logic [ACC_W-1:0] threshold_sq,
  input  logic [PAT_W-1:0] patience,
  input  logic             out_stall,
  output logic             out_valid,
  output cvm_out_t         out_data
);

  logic [ACC_W-1:0] accumulator;
  logic [PAT_W-1:0] small_step_count;
  logic [ACC_W:0]   sum_wide;
  logic [ACC_W-1:0] sum_sat;
  logic             below;
  logic             room;
  logic             fire;
  logic [1:0]       verdict;

  // Saturating add and threshold compare
  assign sum_wide = {1'b0, accumulator} + {{(ACC_W+1-SQ_W){1'b0}}, sq2};
  assign sum_sat  = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];
  assign below    = sum_sat < threshold_sq;
  assign room     = small_step_count < patience;
  assign fire     = en & tag2.valid;

  always_comb begin
    if (below && !room) begin
      verdict = VERDICT_CONVERGED;
    end else begin
      verdict = VERDICT_CONTINUE;
    end
  end

  // Sum and patience state; frozen while over the limit
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator      <= '0;
      small_step_count <= '0;
    end else if (fire && !tag2.over_limit) begin
      if (tag2.last) begin
        accumulator <= '0;
        if (!below) begin
          small_step_count <= '0;
        end else if (room) begin
          small_step_count <= small_step_count + PAT_W'(1);
        end
      end else begin
        accumulator <= sum_sat;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && tag2.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && tag2.last) begin
      if (tag2.over_limit) begin
        out_data.verdict     <= VERDICT_LIMIT;
        out_data.distance_sq <= '0;
      end else begin
        out_data.verdict     <= verdict;
        out_data.distance_sq <= sum_sat;
      end
    end
  end

endmodule

FILE: hdl/convergence_monitor_core.sv
// Top level of the convergence monitor: register file, stall control, stages.
// Depends on cvm_pkg, cvm_front, cvm_square, cvm_accum.
`timescale 1ns / 1ps
//
// Usage:
//   Weight elements enter on in_valid/in_stall/in_data, one word per cycle
//   while in_stall is low, with in_data.last on the final element of a vector.
//   One result word per vector leaves on out_valid/out_stall/out_data: verdict
//   and squared distance. Registers are to be written by the user through
//   wr_en/wr_index/wr_data while the block idles; the block does not enforce it.
//   out_valid of a vector rises once its last element has passed the three
//   register stages (store read, square, accumulate), the first loaded at the
//   edge that accepts it. The result register holds a waiting word; elements
//   keep flowing while it waits, and in_stall rises only when the next result
//   reaches the last stage while the held word is still stalled.
//   Reset clears the control state and resets the configuration registers.
//   The previous vector store is not cleared; the first vector after reset fills it.

module convergence_monitor_core
  import cvm_pkg::*;
#(
  parameter int NUM_WEIGHTS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cvm_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cvm_out_t             out_data,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [ACC_W-1:0]     wr_data
);

  logic [ACC_W-1:0]    threshold_sq;
  logic [ITER_W-1:0]   max_iterations;
  logic [PAT_W-1:0]    patience;
  logic                en;
  cvm_tag_t            tag1;
  cvm_tag_t            tag2;
  logic [WEIGHT_W-1:0] weight1;
  logic [WEIGHT_W-1:0] prev1;
  logic [SQ_W-1:0]     sq2;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_sq   <= '0;
      max_iterations <= '1;
      patience       <= PAT_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_THRESHOLD_SQ:   threshold_sq   <= wr_data;
        REG_MAX_ITERATIONS: max_iterations <= wr_data[ITER_W-1:0];
        REG_PATIENCE:       patience       <= wr_data[PAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline holds only when a new result meets a stalled held result
  assign en       = !(out_valid && out_stall && tag2.valid && tag2.last);
  assign in_stall = !en;

  cvm_front #(
    .NUM_WEIGHTS(NUM_WEIGHTS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (in_valid),
    .in_data        (in_data),
    .max_iterations (max_iterations),
    .tag1           (tag1),
    .weight1        (weight1),
    .prev1          (prev1)
  );

  cvm_square u_square (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag1    (tag1),
    .weight1 (weight1),
    .prev1   (prev1),
    .tag2    (tag2),
    .sq2     (sq2)
  );

  cvm_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .tag2         (tag2),
    .sq2          (sq2),
    .threshold_sq (threshold_sq),
    .patience     (patience),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

endmodule

FILE: hdl/cvm_checker.sv
// Port-level checks for the convergence monitor, bound to the top level.
// Depends on cvm_pkg and convergence_monitor_core.
`timescale 1ns / 1ps

module cvm_checker
  import cvm_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input cvm_out_t out_data
);

  // A stalled result stays up
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result holds its word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result word changed");

  // Input is held back only behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Limit verdict carries no distance
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.verdict == VERDICT_LIMIT |-> out_data.distance_sq == '0)
    else $error("limit verdict with nonzero distance");

  // Reset empties the result register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind convergence_monitor_core cvm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: sim/tb_top.sv
// Self-checking bench for convergence_monitor_core: streams weight vectors,
// predicts every verdict word and compares it on the result port.
// Depends on cvm_pkg and the convergence_monitor_core RTL.
`timescale 1ns / 1ps

module tb_top;
  import cvm_pkg::*;

  localparam int NUM_W          = 256;
  localparam int PHASE_WORDS    = 30;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_CAP     = 100;

  localparam bit [WEIGHT_W-1:0] W_MAX   = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam bit [WEIGHT_W-1:0] W_MIN   = {1'b1, {(WEIGHT_W-1){1'b0}}};
  localparam bit [ACC_W-1:0]    ACC_MAX = '1;
  localparam bit [ITER_W-1:0]   ITER_MAX = '1;
  localparam bit [PAT_W-1:0]    PAT_MAX = '1;

  // Shapes of generated vectors
  typedef enum int {VK_RANDOM, VK_NEAR, VK_REPEAT, VK_FLIP, VK_FILL, VK_PEAK} vec_kind_t;

  // Mirror of the monitor state plus the queue of verdict words still owed
  class verdict_scoreboard;
    bit [WEIGHT_W-1:0] prev_w [NUM_W];
    bit [ACC_W-1:0]    acc;
    int unsigned       elem_idx;
    bit [ITER_W-1:0]   iter_cnt;
    bit [PAT_W-1:0]    step_cnt;
    bit                first_vec;
    bit                limit_hit;
    bit [ACC_W-1:0]    thr_sq;
    bit [ITER_W-1:0]   max_iter;
    bit [PAT_W-1:0]    pat;
    cvm_out_t          verdict_q[$];
    int                errors;
    int                words_n;
    int                results_n;
    int                converged_n;
    int                limit_n;
    int                saturated_n;

    function new();
      acc       = '0;
      elem_idx  = 0;
      iter_cnt  = 1;
      step_cnt  = '0;
      first_vec = 1'b1;
      limit_hit = 1'b0;
      thr_sq    = '0;
      max_iter  = '1;
      pat       = 1;
    endfunction

    function void set_regs(bit [ACC_W-1:0] thr, bit [ITER_W-1:0] mi, bit [PAT_W-1:0] pt);
      thr_sq   = thr;
      max_iter = mi;
      pat      = pt;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // Advance the mirror by one accepted input word
    function void note_word(cvm_in_t w);
      bit signed [DIFF_W-1:0] diff;
      bit [DIFF_W-1:0]        mag;
      bit [SQ_W-1:0]          mag_w;
      bit [SQ_W-1:0]          sq;
      bit [ACC_W:0]           sum;
      cvm_out_t               r;
      words_n++;
      if (elem_idx == 0) limit_hit = iter_cnt > max_iter;
      if (!limit_hit) begin
        if (first_vec) begin
          sq = ONE_Q32;
        end else begin
          diff  = $signed({w.weight[WEIGHT_W-1], w.weight})
                - $signed({prev_w[elem_idx][WEIGHT_W-1], prev_w[elem_idx]});
          mag   = diff[DIFF_W-1] ? -diff : diff;
          mag_w = SQ_W'(mag);
          sq    = mag_w * mag_w;
        end
        prev_w[elem_idx] = w.weight;
        sum = {1'b0, acc} + sq;
        acc = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
      end
      elem_idx = (elem_idx + 1 >= NUM_W) ? 0 : elem_idx + 1;
      if (w.last) begin
        if (limit_hit) begin
          r.verdict     = VERDICT_LIMIT;
          r.distance_sq = '0;
          limit_n++;
        end else begin
          r.verdict     = VERDICT_CONTINUE;
          r.distance_sq = acc;
          if (acc < thr_sq) begin
            if (step_cnt < pat) step_cnt++;
            else r.verdict = VERDICT_CONVERGED;
          end else begin
            step_cnt = '0;
          end
          if (iter_cnt != ITER_MAX) iter_cnt++;
          if (r.verdict == VERDICT_CONVERGED) converged_n++;
          if (acc == ACC_MAX) saturated_n++;
          first_vec = 1'b0;
          acc       = '0;
        end
        elem_idx = 0;
        results_n++;
        verdict_q.push_back(r);
      end
    endfunction

    task report(string what);
      // print is capped so a broken build cannot flood the log; all are counted
      if (errors < REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    // Compare one accepted result word against the oldest owed one
    task check_result(cvm_out_t got);
      cvm_out_t want;
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected result word: verdict %0d distance 0x%0h",
                         got.verdict, got.distance_sq));
      end else begin
        want = verdict_q.pop_front();
        if (got.verdict !== want.verdict)
          report($sformatf("verdict %0d, want %0d", got.verdict, want.verdict));
        if (got.distance_sq !== want.distance_sq)
          report($sformatf("distance_sq 0x%0h, want 0x%0h",
                           got.distance_sq, want.distance_sq));
      end
    endtask
  endclass

  // DUT signals
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  cvm_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  cvm_out_t             out_data;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = REG_THRESHOLD_SQ;
  logic [ACC_W-1:0]     wr_data = '0;

  verdict_scoreboard sb = new();

  // Generator state
  bit [WEIGHT_W-1:0] gen_prev [NUM_W];
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet = 0;
  int n_sent = 0;
  int n_cfg = 0;

  always #5 clk = ~clk;

  convergence_monitor_core #(
    .NUM_WEIGHTS(NUM_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Receiver: random stall, or a counted long hold-off when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Handshake monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_word(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Watchdog on stretches with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet);
        $display("convergence_monitor_core regression: fail");
        $finish;
      end
    end
  end

  // Offer one word; valid stays high afterwards unless the next call idles
  task automatic offer_word(input cvm_in_t w);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_vector(input vec_kind_t kind, input int len);
    cvm_in_t w;
    int      slot;
    for (int i = 0; i < len; i++) begin
      slot = i % NUM_W;
      case (kind)
        VK_RANDOM: w.weight = WEIGHT_W'($urandom);
        VK_NEAR:   w.weight = gen_prev[slot] + WEIGHT_W'($urandom_range(6)) - WEIGHT_W'(3);
        VK_REPEAT: w.weight = gen_prev[slot];
        VK_FLIP:   w.weight = (gen_prev[slot] == W_MAX) ? W_MIN : W_MAX;
        VK_FILL:   w.weight = (i == 0) ? W_MIN : (i == 1) ? W_MAX : WEIGHT_W'($urandom);
        default:   w.weight = W_MAX;
      endcase
      w.last = (i == len - 1);
      gen_prev[slot] = w.weight;
      offer_word(w);
    end
  endtask

  function automatic vec_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 45) return VK_NEAR;
    if (r < 70) return VK_REPEAT;
    if (r < 85) return VK_RANDOM;
    return VK_FLIP;
  endfunction

  // Drop valid and wait until every owed word is out and the pipe is empty
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers; upper data bits carry junk the block must drop
  task automatic program_regs(input bit [ACC_W-1:0] thr, input bit [ITER_W-1:0] mi,
                              input bit [PAT_W-1:0] pt);
    bit [ACC_W-1:0] junk;
    junk = ACC_W'({$urandom, $urandom});
    wr_en    <= 1'b1;
    wr_index <= REG_THRESHOLD_SQ;
    wr_data  <= thr;
    @(posedge clk);
    wr_index <= REG_MAX_ITERATIONS;
    wr_data  <= {junk[ACC_W-1:ITER_W], mi};
    @(posedge clk);
    wr_index <= REG_PATIENCE;
    wr_data  <= {junk[ACC_W-1:PAT_W], pt};
    @(posedge clk);
    wr_en <= 1'b0;
    sb.set_regs(thr, mi, pt);
    n_cfg++;
  endtask

  // Register setting for random phase p, rotating through the extremes
  task automatic program_phase(input int p);
    bit [ACC_W-1:0]  thr;
    bit [ITER_W-1:0] mi;
    bit [PAT_W-1:0]  pt;
    case (p % 4)
      0:       thr = ACC_W'($urandom_range(600, 1));
      1:       thr = ACC_MAX;
      2:       thr = ACC_W'({$urandom, $urandom});
      default: thr = '0;
    endcase
    case (p % 4)
      0:       mi = ITER_MAX;
      1:       mi = sb.iter_cnt + ITER_W'($urandom_range(6, 2));
      2:       mi = $urandom;
      default: mi = sb.iter_cnt + ITER_W'($urandom_range(10, 3));
    endcase
    case (p % 3)
      0:       pt = PAT_W'($urandom_range(3));
      1:       pt = PAT_W'($urandom_range(2, 1));
      default: pt = (p == 2) ? PAT_MAX : PAT_W'($urandom);
    endcase
    program_regs(thr, mi, pt);
  endtask

  initial begin : stimulus
    int start;
    int r;
    int len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Over the limit from the very first vector: nothing may be stored
    snd_idle_pct = 28;
    rcv_idle_pct = 66;
    program_regs(ACC_MAX, '0, '0);
    send_vector(VK_FILL, 3);
    send_vector(VK_FILL, 1);
    drain_block();

    // First real vector, overlong so it wraps and fills the whole store
    program_regs(ACC_MAX, ITER_MAX, '0);
    send_vector(VK_FILL, NUM_W + 4);
    drain_block();

    // Patience walk: two small steps, then converged, then large steps
    program_regs(ACC_W'(64'd1 << 32), ITER_MAX, PAT_W'(2));
    repeat (3) send_vector(VK_REPEAT, 3);
    send_vector(VK_FLIP, 3);
    send_vector(VK_FLIP, 2);
    send_vector(VK_FLIP, 1);
    drain_block();

    // Long receiver hold-off while the sender keeps pushing short vectors
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req <= hold_req + 1;
    repeat (40) send_vector(pick_kind(), $urandom_range(3, 1));
    drain_block();

    // Random phases over three idle regimes and rotating register settings
    for (int regime = 0; regime < 3; regime++) begin
      snd_idle_pct = (regime == 0) ? 28 : (regime == 1) ? 66 : 0;
      rcv_idle_pct = (regime == 0) ? 66 : (regime == 1) ? 28 : 0;
      for (int k = 0; k < 3; k++) begin
        program_phase(regime * 3 + k);
        start = n_sent;
        if (regime == 1 && k == 1) begin
          // full-scale steps give the largest square an element can add
          send_vector(VK_PEAK, 16);
          send_vector(VK_FLIP, 48);
        end
        while (n_sent - start < PHASE_WORDS) begin
          r = $urandom_range(99);
          if (r < 80) len = $urandom_range(6, 1);
          else if (r < 99) len = $urandom_range(24, 7);
          else len = $urandom_range(NUM_W + 24, NUM_W + 1);
          send_vector(pick_kind(), len);
        end
        drain_block();
      end
    end

    $display("run covered %0d input words, %0d verdict words over %0d register settings",
             sb.words_n, sb.results_n, n_cfg);
    $display("  %0d converged, %0d at iteration limit, %0d with saturated distance",
             sb.converged_n, sb.limit_n, sb.saturated_n);
    if (sb.errors == 0) begin
      $display("convergence_monitor_core regression: pass");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("convergence_monitor_core regression: fail");
    end
    $finish;
  end

endmodule
